// ===== rtl/core/csmv_pkg.sv =====
// Shared types and constants for the COO sparse matrix-vector multiply block.
// Holds the command codes, the classified operation record and the register map.
// No dependencies.
package csmv_pkg;

  // Fixed field widths of the item interface.
  localparam int DATA_W = 32;
  localparam int ROW_W  = 32;
  localparam int COL_W  = 10;
  // Local y index width that covers the largest supported row count.
  localparam int LIDX_W = 16;
  // Depth of the queue between the front and back ends.
  localparam int QDEPTH = 2;

  // Register map: the word index is taken from paddr[2].
  localparam logic REG_IDX_ROW_BASE = 1'b0;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_LOAD_X  = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_READ_Y  = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e_t;

  // Operation class assigned by the front end.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NZ   = 2'd1,
    OP_READ = 2'd2,
    OP_BAD  = 2'd3
  } op_kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_kind_t            kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [LIDX_W-1:0]   lidx;
    logic [DATA_W-1:0]   value;
    logic                last;
  } op_t;

  // Control inputs that the front end needs from the rest of the block.
  typedef struct packed {
    logic clearing;
    logic q_full;
  } front_ctl_t;

endpackage

// ===== rtl/core/csmv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the x and y vector stores. No dependencies.
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/csmv_front.sv =====
// Front end: accepts items, checks index ranges and classifies each command.
// Depends on csmv_pkg.
module csmv_front import csmv_pkg::*; #(
  parameter int ROWS = 1024,
  parameter int COLS = 1024
) (
  input  logic              in_valid,
  input  logic [1:0]        cmd,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [DATA_W-1:0] value,
  input  logic              last,
  input  logic [ROW_W-1:0]  row_base,
  input  front_ctl_t        ctl,
  output logic              in_stall,
  output logic              push,
  output op_t               op
);

  logic [ROW_W-1:0] local_row;
  logic             col_ok;
  logic             local_ok;
  logic             read_ok;

  // Range checks against the configured sizes.
  assign local_row = row - row_base;
  assign col_ok    = 32'(col) < 32'(COLS);
  assign local_ok  = local_row < 32'(ROWS);
  assign read_ok   = row < 32'(ROWS);

  // No item is taken during the clear pass or while the queue is full.
  assign in_stall = ctl.clearing || ctl.q_full;
  assign push     = in_valid && !in_stall;

  // Classify the command and select the y index it uses.
  always_comb begin
    op.row   = row;
    op.col   = col;
    op.value = value;
    op.last  = last;
    op.lidx  = LIDX_W'(local_row);
    op.kind  = OP_BAD;
    case (cmd_e_t'(cmd))
      CMD_LOAD_X: begin
        if (col_ok) begin
          op.kind = OP_LOAD;
        end
      end
      CMD_NONZERO: begin
        if (col_ok && local_ok) begin
          op.kind = OP_NZ;
        end
      end
      CMD_READ_Y: begin
        op.lidx = LIDX_W'(row);
        if (read_ok) begin
          op.kind = OP_READ;
        end
      end
      default: begin
        op.kind = OP_BAD;
      end
    endcase
  end

endmodule

// ===== rtl/core/csmv_queue.sv =====
// Short FIFO of classified operations between the front and back ends.
// Depends on csmv_pkg.
module csmv_queue import csmv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output op_t  head_op
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  op_t           entries [QDEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;

  assign q_valid = count != '0;
  assign q_full  = count == CW'(QDEPTH);
  assign head_op = entries[head];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(QDEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PW'(QDEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/csmv_back.sv =====
// Back end: sequencer that runs queued operations against the x and y stores,
// keeps the running row sum and drives the result register.
// Depends on csmv_pkg and csmv_ram.
module csmv_back import csmv_pkg::*; #(
  parameter int ROWS = 1024,
  parameter int COLS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ROW_W-1:0]  row_base,
  input  logic              q_valid,
  input  op_t               head_op,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] y_value,
  output logic              status
);

  localparam int XW = $clog2(COLS);
  localparam int YW = $clog2(ROWS);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_XRD   = 7'b0000100,
    ST_MAC   = 7'b0001000,
    ST_FLUSH = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [YW-1:0]     clr_addr, clr_addr_next;
  op_t               op_r, op_r_next;
  logic [DATA_W-1:0] prod, prod_next;
  logic [DATA_W-1:0] row_sum, row_sum_next;
  logic [ROW_W-1:0]  current_row, current_row_next;
  logic              row_open, row_open_next;
  logic [YW-1:0]     fl_addr, fl_addr_next;
  logic              fl_en, fl_en_next;
  logic              fl_ret_mac, fl_ret_mac_next;
  logic [DATA_W-1:0] res_y, res_y_next;
  logic              res_status, res_status_next;
  logic              out_valid_next;
  logic [DATA_W-1:0] y_value_next;
  logic              status_next;

  logic              x_we;
  logic [XW-1:0]     x_raddr;
  logic [DATA_W-1:0] x_rdata;
  logic              y_we;
  logic [YW-1:0]     y_waddr;
  logic [DATA_W-1:0] y_wdata;
  logic [YW-1:0]     y_raddr;
  logic [DATA_W-1:0] y_rdata;

  logic [ROW_W-1:0]  old_local;
  logic              old_ok;

  // Vector stores.
  csmv_ram #(.WIDTH(DATA_W), .DEPTH(COLS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (XW'(head_op.col)),
    .wdata (head_op.value),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  csmv_ram #(.WIDTH(DATA_W), .DEPTH(ROWS)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  assign clearing  = state == ST_CLEAR;
  // Local index of the open row under the row base now in force.
  assign old_local = current_row - row_base;
  assign old_ok    = old_local < 32'(ROWS);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    op_r_next        = op_r;
    prod_next        = prod;
    row_sum_next     = row_sum;
    current_row_next = current_row;
    row_open_next    = row_open;
    fl_addr_next     = fl_addr;
    fl_en_next       = fl_en;
    fl_ret_mac_next  = fl_ret_mac;
    res_y_next       = res_y;
    res_status_next  = res_status;
    y_value_next     = y_value;
    status_next      = status;
    out_valid_next   = out_valid && out_stall;
    pop              = 1'b0;
    x_we             = 1'b0;
    x_raddr          = XW'(head_op.col);
    y_we             = 1'b0;
    y_waddr          = clr_addr;
    y_wdata          = '0;
    y_raddr          = YW'(head_op.lidx);
    case (state)
      ST_CLEAR: begin
        // Zero one y entry per cycle after reset.
        y_we          = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == YW'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop             = 1'b1;
          op_r_next       = head_op;
          res_y_next      = '0;
          res_status_next = 1'b0;
          case (head_op.kind)
            OP_LOAD: begin
              x_we       = 1'b1;
              state_next = ST_DONE;
            end
            OP_NZ: begin
              state_next = ST_XRD;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
            default: begin
              res_status_next = 1'b1;
              state_next      = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_y_next = y_rdata;
        state_next = ST_DONE;
      end
      ST_XRD: begin
        // Product keeps the low word only.
        prod_next  = DATA_W'(op_r.value * x_rdata);
        state_next = ST_MAC;
      end
      ST_MAC: begin
        if (row_open && (op_r.row != current_row)) begin
          // Row changed: fold the old sum into y first, then come back.
          y_raddr         = YW'(old_local);
          fl_addr_next    = YW'(old_local);
          fl_en_next      = old_ok;
          fl_ret_mac_next = 1'b1;
          state_next      = ST_FLUSH;
        end else begin
          row_sum_next     = row_sum + prod;
          current_row_next = op_r.row;
          row_open_next    = 1'b1;
          if (op_r.last) begin
            y_raddr         = YW'(op_r.lidx);
            fl_addr_next    = YW'(op_r.lidx);
            fl_en_next      = 1'b1;
            fl_ret_mac_next = 1'b0;
            state_next      = ST_FLUSH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FLUSH: begin
        // Read-modify-write of the y entry, then close the row.
        y_we          = fl_en;
        y_waddr       = fl_addr;
        y_wdata       = y_rdata + row_sum;
        row_sum_next  = '0;
        row_open_next = 1'b0;
        state_next    = fl_ret_mac ? ST_MAC : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          y_value_next   = res_y;
          status_next    = res_status;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      row_sum     <= '0;
      current_row <= '0;
      row_open    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      row_sum     <= row_sum_next;
      current_row <= current_row_next;
      row_open    <= row_open_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    prod       <= prod_next;
    fl_addr    <= fl_addr_next;
    fl_en      <= fl_en_next;
    fl_ret_mac <= fl_ret_mac_next;
    res_y      <= res_y_next;
    res_status <= res_status_next;
    y_value    <= y_value_next;
    status     <= status_next;
  end

endmodule

// ===== rtl/core/coo_sparse_matrix_vector_multiply.sv =====
// Top level of the COO sparse matrix-vector multiply block.
// Depends on csmv_pkg, csmv_front, csmv_queue, csmv_back and csmv_ram.
//
// Load x with command 0, stream nonzeros with command 1 grouped by row, and
// read y back with command 2; every item returns exactly one result. After
// reset the block zeroes the y store and stalls its input meanwhile. The
// front end classifies an item in the cycle it is taken and queues it; the
// back-end sequencer then runs one item at a time, limited by the registered
// reads of the x and y memories: a load or a rejected item goes from idle
// to done, a read adds a y read state, a nonzero an x read state and a
// multiply-accumulate state, and a y update adds a flush state. A two-entry
// queue lets new items enter while the back end works; the result register
// lets the back end finish while the previous result is still stalled.
module coo_sparse_matrix_vector_multiply import csmv_pkg::*; #(
  parameter int ROWS = 1024,
  parameter int COLS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input items.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [DATA_W-1:0] value,
  input  logic              last,
  // Result items.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] y_value,
  output logic              status
);

  logic [ROW_W-1:0] row_base;
  front_ctl_t       front_ctl;
  logic             push;
  op_t              push_op;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  op_t              head_op;
  logic             clearing;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_ROW_BASE) ? row_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_base <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_ROW_BASE)) begin
      row_base <= pwdata;
    end
  end

  assign front_ctl.clearing = clearing;
  assign front_ctl.q_full   = q_full;

  // Front end: accept and classify.
  csmv_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .in_valid (in_valid),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .value    (value),
    .last     (last),
    .row_base (row_base),
    .ctl      (front_ctl),
    .in_stall (in_stall),
    .push     (push),
    .op       (push_op)
  );

  // Queue between the two halves.
  csmv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .head_op (head_op)
  );

  // Back end: execute against the stores.
  csmv_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .row_base  (row_base),
    .q_valid   (q_valid),
    .head_op   (head_op),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .y_value   (y_value),
    .status    (status)
  );

  // No item may enter while the y store is being cleared.
  a_stall_in_clear: assert property (@(posedge clk) clearing |-> in_stall)
    else $error("item accepted during the clear pass");

  // The clear pass runs only once after reset.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clear pass restarted without reset");

  // A result can only appear once the clear pass is over.
  a_result_after_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(clearing))
    else $error("result produced during the clear pass");

endmodule
